// File: design/frt_pkg.sv
// Shared types and constants for the fragment reassembly tracker.
// Used by every module of the block; depends on nothing.
package frt_pkg;

  // Protocol and sizing constants.
  localparam int unsigned FRAG_MAX    = 1024;
  localparam int unsigned PAYLOAD_MAX = 64;
  localparam logic [7:0]  PROTO_VER   = 8'd1;

  // Bitmap geometry: one memory row holds ROW_W received bits.
  localparam int unsigned ROW_W     = 32;
  localparam int unsigned BIT_W     = $clog2(ROW_W);
  localparam int unsigned ROWS      = FRAG_MAX / ROW_W;
  localparam int unsigned ROW_IDX_W = $clog2(ROWS);
  localparam int unsigned IDX_W     = $clog2(FRAG_MAX);
  localparam int unsigned CNT_W     = $clog2(FRAG_MAX + 1);
  localparam int unsigned SLOT_W    = 10;

  // Verdict codes.
  localparam logic [1:0] VERDICT_STORED    = 2'd0;
  localparam logic [1:0] VERDICT_MALFORMED = 2'd1;
  localparam logic [1:0] VERDICT_REJECTED  = 2'd2;
  localparam logic [1:0] VERDICT_COMPLETE  = 2'd3;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_LOCAL_ADDR  = 2'd0;
  localparam logic [1:0] REG_LOWEST_TYPE = 2'd1;
  localparam logic [1:0] REG_HIGHEST_TYPE = 2'd2;

  // Configuration register values.
  typedef struct packed {
    logic [7:0] local_address;
    logic [7:0] lowest_type;
    logic [7:0] highest_type;
  } frt_cfg_t;

  // Fragment header as it enters the tracking stage.
  typedef struct packed {
    logic        malformed;
    logic [7:0]  msg_type;
    logic [7:0]  sender;
    logic [63:0] session;
    logic [31:0] sequence_req;
    logic [15:0] frag_index;
    logic [15:0] frag_count;
  } frt_hdr_t;

  // One result word.
  typedef struct packed {
    logic              started_new;
    logic [SLOT_W-1:0] store_slot;
    logic [1:0]        verdict;
  } frt_result_t;

  // Bitmap memory write port.
  typedef struct packed {
    logic                 en;
    logic [ROW_IDX_W-1:0] row;
    logic [ROW_W-1:0]     data;
  } frt_wr_t;

endpackage

// File: design/fragment_reassembly_tracker.sv
// Fragment reassembly tracker: takes one fragment header word per cycle while the output is
// not stalled and returns one verdict word per header through the header register and the
// output register. The rate is set by the received-fragment bitmap memory (32 rows of 32
// bits), read once when a header is accepted and written back when a stored fragment does
// not finish its message; a write to the row being read at the same edge is forwarded. The bitmap
// is cleared for a new message, on completion and at reset through per-row valid flags, so
// there is no clearing pass. Depends on frt_pkg, frt_cfg_regs, frt_bitmap_mem, frt_assembly.
module fragment_reassembly_tracker (
  input  logic         clk,
  input  logic         rst_n,
  // Fields from bit 0 up: version[7:0], msg_type[15:8], sender[23:16], receiver[31:24],
  // session[95:32], sequence_req[127:96], frag_index[143:128], frag_count[159:144],
  // payload_length[175:160].
  input  logic [175:0] in_tdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0 up: verdict[1:0], store_slot[11:2], started_new[12], zero fill.
  output logic [15:0]  out_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [3:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  frt_pkg::frt_cfg_t    cfg;
  frt_pkg::frt_hdr_t    hdr_in;
  frt_pkg::frt_hdr_t    hdr_r;
  frt_pkg::frt_result_t result;
  frt_pkg::frt_result_t out_r;
  frt_pkg::frt_wr_t     wr;
  logic [frt_pkg::ROW_W-1:0] row_data;
  logic                 s1_valid_r;
  logic                 out_valid_r;
  logic                 s1_adv;
  logic                 in_accept;

  logic [7:0]  f_version;
  logic [7:0]  f_receiver;
  logic [15:0] f_length;

  frt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Unpack the input word and check the header for malformed fields.
  assign f_version  = in_tdata[7:0];
  assign f_receiver = in_tdata[31:24];
  assign f_length   = in_tdata[175:160];

  always_comb begin
    hdr_in.msg_type     = in_tdata[15:8];
    hdr_in.sender       = in_tdata[23:16];
    hdr_in.session      = in_tdata[95:32];
    hdr_in.sequence_req = in_tdata[127:96];
    hdr_in.frag_index   = in_tdata[143:128];
    hdr_in.frag_count   = in_tdata[159:144];
    hdr_in.malformed    = (f_version != frt_pkg::PROTO_VER) ||
                          (hdr_in.msg_type < cfg.lowest_type) ||
                          (hdr_in.msg_type > cfg.highest_type) ||
                          (hdr_in.frag_count == 16'd0) ||
                          (hdr_in.frag_count > 16'(frt_pkg::FRAG_MAX)) ||
                          (hdr_in.frag_index >= hdr_in.frag_count) ||
                          (f_length > 16'(frt_pkg::PAYLOAD_MAX)) ||
                          (f_receiver != cfg.local_address);
  end

  // Handshake: the decision stage moves on whenever the output register is free or drains.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  // Header register in front of the decision stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      hdr_r <= hdr_in;
    end
  end

  frt_bitmap_mem u_mem (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_row  (hdr_in.frag_index[frt_pkg::IDX_W-1:frt_pkg::BIT_W]),
    .rd_data (row_data),
    .wr      (wr)
  );

  frt_assembly u_asm (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (s1_adv),
    .hdr      (hdr_r),
    .row_data (row_data),
    .result   (result),
    .wr       (wr)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, out_r};

endmodule

// File: design/frt_cfg_regs.sv
// Configuration registers of the fragment reassembly tracker behind an APB-style port.
// Depends on frt_pkg.
module frt_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output frt_pkg::frt_cfg_t cfg
);

  frt_pkg::frt_cfg_t cfg_r;
  logic [1:0]        reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register writes; an address beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.local_address <= 8'd0;
      cfg_r.lowest_type   <= 8'd1;
      cfg_r.highest_type  <= 8'd4;
    end else if (wr_en) begin
      case (reg_idx)
        frt_pkg::REG_LOCAL_ADDR:   cfg_r.local_address <= pwdata[7:0];
        frt_pkg::REG_LOWEST_TYPE:  cfg_r.lowest_type   <= pwdata[7:0];
        frt_pkg::REG_HIGHEST_TYPE: cfg_r.highest_type  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      frt_pkg::REG_LOCAL_ADDR:   prdata = {24'd0, cfg_r.local_address};
      frt_pkg::REG_LOWEST_TYPE:  prdata = {24'd0, cfg_r.lowest_type};
      frt_pkg::REG_HIGHEST_TYPE: prdata = {24'd0, cfg_r.highest_type};
      default:                   prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// File: design/frt_bitmap_mem.sv
// Received-fragment bitmap memory: one write and one registered read per cycle.
// A read of the row written at the same edge returns the new data. Depends on frt_pkg.
module frt_bitmap_mem (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [frt_pkg::ROW_IDX_W-1:0] rd_row,
  output logic [frt_pkg::ROW_W-1:0]     rd_data,
  input  frt_pkg::frt_wr_t              wr
);

  logic [frt_pkg::ROW_W-1:0] mem [frt_pkg::ROWS];
  logic [frt_pkg::ROW_W-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row] <= wr.data;
    end
  end

  // Read port, forwarding a write to the same row.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.row == rd_row)) begin
        rd_data_r <= wr.data;
      end else begin
        rd_data_r <= mem[rd_row];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/frt_assembly.sv
// Message assembly state and per-fragment decision of the fragment reassembly tracker.
// Holds the current message identity, fill total and row-valid flags. Depends on frt_pkg.
module frt_assembly (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  frt_pkg::frt_hdr_t         hdr,
  input  logic [frt_pkg::ROW_W-1:0] row_data,
  output frt_pkg::frt_result_t      result,
  output frt_pkg::frt_wr_t          wr
);

  localparam int unsigned CNT_W = frt_pkg::CNT_W;

  logic [7:0]              cur_type_r,     cur_type_nxt;
  logic [7:0]              cur_sender_r,   cur_sender_nxt;
  logic [63:0]             cur_session_r,  cur_session_nxt;
  logic [31:0]             cur_sequence_r, cur_sequence_nxt;
  logic [CNT_W-1:0]        cur_count_r,    cur_count_nxt;
  logic [CNT_W-1:0]        total_r,        total_nxt;
  logic [frt_pkg::ROWS-1:0] row_valid_r,   row_valid_nxt;

  logic [frt_pkg::ROW_IDX_W-1:0] row;
  logic [frt_pkg::BIT_W-1:0]     bit_sel;
  logic [frt_pkg::ROW_W-1:0]     row_bits;
  logic [frt_pkg::ROW_W-1:0]     base_bits;
  logic [CNT_W-1:0]              eff_count;
  logic [CNT_W-1:0]              eff_total;
  logic [CNT_W-1:0]              new_total;
  logic                          ident_diff;
  logic                          started;
  logic                          reject;
  logic                          stored;
  logic                          complete;

  assign row     = hdr.frag_index[frt_pkg::IDX_W-1:frt_pkg::BIT_W];
  assign bit_sel = hdr.frag_index[frt_pkg::BIT_W-1:0];

  // A row that has not been written since the last clear reads as empty.
  assign row_bits = row_valid_r[row] ? row_data : '0;

  // Identity compare and the decision for this fragment.
  assign ident_diff = (cur_session_r != hdr.session) || (cur_type_r != hdr.msg_type) ||
                      (cur_sender_r != hdr.sender) || (cur_sequence_r != hdr.sequence_req);
  assign started    = !hdr.malformed && ident_diff;
  assign eff_count  = started ? hdr.frag_count[CNT_W-1:0] : cur_count_r;
  assign eff_total  = started ? '0 : total_r;
  assign base_bits  = started ? '0 : row_bits;
  assign reject     = !hdr.malformed &&
                      (({{(16-CNT_W){1'b0}}, eff_count} != hdr.frag_count) || base_bits[bit_sel]);
  assign stored     = !hdr.malformed && !reject;
  assign new_total  = eff_total + 1'b1;
  assign complete   = stored && (new_total >= eff_count);

  // Result word.
  always_comb begin
    if (hdr.malformed) begin
      result.verdict = frt_pkg::VERDICT_MALFORMED;
    end else if (reject) begin
      result.verdict = frt_pkg::VERDICT_REJECTED;
    end else if (complete) begin
      result.verdict = frt_pkg::VERDICT_COMPLETE;
    end else begin
      result.verdict = frt_pkg::VERDICT_STORED;
    end
    result.store_slot  = stored ? hdr.frag_index[frt_pkg::SLOT_W-1:0] : '0;
    result.started_new = started;
  end

  // Bitmap row write-back for a stored fragment that does not finish the message.
  always_comb begin
    wr.en   = advance && stored && !complete;
    wr.row  = row;
    wr.data = base_bits | (frt_pkg::ROW_W'(1) << bit_sel);
  end

  // Next assembly state.
  always_comb begin
    cur_type_nxt     = cur_type_r;
    cur_sender_nxt   = cur_sender_r;
    cur_session_nxt  = cur_session_r;
    cur_sequence_nxt = cur_sequence_r;
    cur_count_nxt    = cur_count_r;
    total_nxt        = total_r;
    row_valid_nxt    = row_valid_r;
    if (advance && stored) begin
      if (complete) begin
        cur_type_nxt     = '0;
        cur_sender_nxt   = '0;
        cur_session_nxt  = '0;
        cur_sequence_nxt = '0;
        cur_count_nxt    = '0;
        total_nxt        = '0;
        row_valid_nxt    = '0;
      end else begin
        if (started) begin
          cur_type_nxt     = hdr.msg_type;
          cur_sender_nxt   = hdr.sender;
          cur_session_nxt  = hdr.session;
          cur_sequence_nxt = hdr.sequence_req;
          cur_count_nxt    = eff_count;
          row_valid_nxt    = '0;
        end
        total_nxt          = new_total;
        row_valid_nxt[row] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_type_r     <= '0;
      cur_sender_r   <= '0;
      cur_session_r  <= '0;
      cur_sequence_r <= '0;
      cur_count_r    <= '0;
      total_r        <= '0;
      row_valid_r    <= '0;
    end else begin
      cur_type_r     <= cur_type_nxt;
      cur_sender_r   <= cur_sender_nxt;
      cur_session_r  <= cur_session_nxt;
      cur_sequence_r <= cur_sequence_nxt;
      cur_count_r    <= cur_count_nxt;
      total_r        <= total_nxt;
      row_valid_r    <= row_valid_nxt;
    end
  end

endmodule

// File: design/frt_checker.sv
// Port-level checks for the fragment reassembly tracker, bound to the top level.
// Depends on fragment_reassembly_tracker's ports and on frt_pkg for the verdict codes.
module frt_checker (
  input logic         clk,
  input logic         rst_n,
  input logic [15:0]  out_tdata,
  input logic         out_tvalid,
  input logic         out_tready
);

  // A stalled result word holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word present after reset");

  // Malformed and rejected words carry no slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == frt_pkg::VERDICT_MALFORMED ||
                   out_tdata[1:0] == frt_pkg::VERDICT_REJECTED) |-> out_tdata[11:2] == 10'd0)
    else $error("slot reported for a fragment that was not stored");

  // A fragment that began a new message was well formed and was stored.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> (out_tdata[1:0] == frt_pkg::VERDICT_STORED ||
                                     out_tdata[1:0] == frt_pkg::VERDICT_COMPLETE))
    else $error("new message flagged on a dropped fragment");

endmodule

bind fragment_reassembly_tracker frt_checker u_frt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);

// File: dv/tb_fragment_reassembly_tracker.sv
// Self-checking testbench for fragment_reassembly_tracker: drives header words and APB writes,
// predicts each verdict word and compares it field by field. Depends on frt_pkg and the RTL.
module tb_fragment_reassembly_tracker;

  localparam int unsigned QUIET_LIMIT = 600;

  // Header word layout, last field in the highest bits.
  typedef struct packed {
    logic [15:0] payload_length;
    logic [15:0] frag_count;
    logic [15:0] frag_index;
    logic [31:0] sequence_req;
    logic [63:0] session;
    logic [7:0]  receiver;
    logic [7:0]  sender;
    logic [7:0]  msg_type;
    logic [7:0]  version;
  } frag_hdr_t;

  // Identity of one message under assembly.
  typedef struct {
    logic [7:0]  msg_type;
    logic [7:0]  sender;
    logic [63:0] session;
    logic [31:0] sequence_req;
  } msg_id_t;

  // Ways a well-formed header is broken.
  typedef enum int {
    BAD_VERSION, BAD_TYPE, BAD_ZERO_COUNT, BAD_HUGE_COUNT, BAD_INDEX, BAD_LENGTH,
    BAD_RECEIVER, BAD_RANDOM, BAD_KINDS
  } defect_t;

  // Tracks the assembly state and holds the verdicts still to come.
  class verdict_scoreboard;
    logic [7:0]                   local_address, lowest_type, highest_type;
    logic [7:0]                   cur_type, cur_sender;
    logic [63:0]                  cur_session;
    logic [31:0]                  cur_sequence;
    logic [frt_pkg::CNT_W-1:0]    cur_count, received_total;
    logic [frt_pkg::FRAG_MAX-1:0] received_map;
    frt_pkg::frt_result_t         expected_verdicts[$];
    int unsigned                  fails;

    function new();
      local_address = 8'd0;
      lowest_type   = 8'd1;
      highest_type  = 8'd4;
      fails         = 0;
      clear_message();
    endfunction

    function void clear_message();
      cur_type       = '0;
      cur_sender     = '0;
      cur_session    = '0;
      cur_sequence   = '0;
      cur_count      = '0;
      received_total = '0;
      received_map   = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        frt_pkg::REG_LOCAL_ADDR:   local_address = val;
        frt_pkg::REG_LOWEST_TYPE:  lowest_type = val;
        frt_pkg::REG_HIGHEST_TYPE: highest_type = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_verdicts.size();
    endfunction

    // Works out the verdict for one accepted header word.
    function void note_fragment(frag_hdr_t f);
      frt_pkg::frt_result_t want;
      want.verdict     = frt_pkg::VERDICT_MALFORMED;
      want.store_slot  = '0;
      want.started_new = 1'b0;
      if (f.version != frt_pkg::PROTO_VER || f.msg_type < lowest_type ||
          f.msg_type > highest_type || f.frag_count == 0 ||
          f.frag_count > frt_pkg::FRAG_MAX || f.frag_index >= f.frag_count ||
          f.payload_length > frt_pkg::PAYLOAD_MAX || f.receiver != local_address) begin
        expected_verdicts = {expected_verdicts, want};
        return;
      end
      // A different identity starts a new message with an empty bitmap.
      if (cur_session != f.session || cur_type != f.msg_type || cur_sender != f.sender ||
          cur_sequence != f.sequence_req) begin
        clear_message();
        cur_type     = f.msg_type;
        cur_sender   = f.sender;
        cur_session  = f.session;
        cur_sequence = f.sequence_req;
        cur_count    = f.frag_count[frt_pkg::CNT_W-1:0];
        want.started_new = 1'b1;
      end
      if (cur_count != f.frag_count || received_map[f.frag_index[frt_pkg::IDX_W-1:0]]) begin
        want.verdict = frt_pkg::VERDICT_REJECTED;
      end else begin
        received_map[f.frag_index[frt_pkg::IDX_W-1:0]] = 1'b1;
        received_total++;
        want.store_slot = f.frag_index[frt_pkg::SLOT_W-1:0];
        if (received_total >= cur_count) begin
          want.verdict = frt_pkg::VERDICT_COMPLETE;
          clear_message();
        end else begin
          want.verdict = frt_pkg::VERDICT_STORED;
        end
      end
      expected_verdicts = {expected_verdicts, want};
    endfunction

    // Compares one accepted verdict word with the oldest expectation.
    function void check_verdict(logic [15:0] word);
      frt_pkg::frt_result_t got, want;
      got = word[$bits(frt_pkg::frt_result_t)-1:0];
      if (expected_verdicts.size() == 0) begin
        $error("verdict word %h arrived with no header waiting for it", word);
        fails++;
        return;
      end
      want = expected_verdicts.pop_front();
      if (got.verdict !== want.verdict) begin
        $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
        fails++;
      end
      if (got.store_slot !== want.store_slot) begin
        $error("store_slot: expected %0d, actual %0d", want.store_slot, got.store_slot);
        fails++;
      end
      if (got.started_new !== want.started_new) begin
        $error("started_new: expected %0d, actual %0d", want.started_new, got.started_new);
        fails++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n;
  logic [175:0] in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [15:0]  out_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic         cfg_psel, cfg_penable, cfg_pwrite;
  logic [3:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  verdict_scoreboard sb = new();
  logic        no_idle = 1'b0;
  int unsigned sent_total = 0;
  int unsigned quiet_cycles = 0;

  fragment_reassembly_tracker u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #4 clk = ~clk;

  // Monitors on both channels, plus a watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_fragment(in_tdata);
      if (out_tvalid && out_tready) sb.check_verdict(out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL fragment_reassembly_tracker");
        $finish;
      end
    end
  end

  // Result side: a random stall before each word, none while no_idle is set.
  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(14, 0);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Sends one header word after a random gap; returns at the accepting edge.
  task automatic send_fragment(frag_hdr_t f);
    int gap;
    gap = no_idle ? 0 : $urandom_range(14, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= f;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sent_total++;
  endtask

  // APB write followed by a read back of the same register, then the bus is released.
  task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, val};
    cfg_pwrite  <= 1'b1;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.write_reg(idx, val);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== {24'd0, val}) begin
      $error("prdata of register %0d: expected %0h, actual %0h", idx, val, cfg_prdata);
      sb.fails++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until the block is idle, then loads all three registers.
  task automatic set_config(logic [7:0] addr, logic [7:0] lo, logic [7:0] hi);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (3) @(posedge clk);
    write_cfg(frt_pkg::REG_LOCAL_ADDR, addr);
    write_cfg(frt_pkg::REG_LOWEST_TYPE, lo);
    write_cfg(frt_pkg::REG_HIGHEST_TYPE, hi);
  endtask

  function automatic msg_id_t random_id();
    msg_id_t id;
    if (sb.lowest_type <= sb.highest_type) id.msg_type = 8'($urandom_range(sb.highest_type,
                                                                           sb.lowest_type));
    else id.msg_type = 8'($urandom_range(255, 0));
    id.sender       = 8'($urandom_range(255, 0));
    id.session      = {$urandom, $urandom};
    id.sequence_req = $urandom;
    return id;
  endfunction

  function automatic frag_hdr_t make_frag(msg_id_t id, int idx, int cnt);
    frag_hdr_t f;
    f.version        = frt_pkg::PROTO_VER;
    f.msg_type       = id.msg_type;
    f.sender         = id.sender;
    f.receiver       = sb.local_address;
    f.session        = id.session;
    f.sequence_req   = id.sequence_req;
    f.frag_index     = 16'(idx);
    f.frag_count     = 16'(cnt);
    f.payload_length = 16'($urandom_range(frt_pkg::PAYLOAD_MAX, 0));
    return f;
  endfunction

  // Breaks one rule of a well-formed header, or replaces it with noise.
  function automatic frag_hdr_t break_frag(frag_hdr_t f);
    defect_t kind;
    kind = defect_t'($urandom_range(BAD_KINDS - 1, 0));
    case (kind)
      BAD_VERSION: begin
        f.version = 8'($urandom_range(255, 0));
        if (f.version == frt_pkg::PROTO_VER) f.version = 8'd0;
      end
      BAD_TYPE: begin
        if (sb.lowest_type > 0 && (sb.highest_type == 8'hFF || $urandom_range(1, 0)))
          f.msg_type = 8'($urandom_range(sb.lowest_type - 1, 0));
        else if (sb.highest_type < 8'hFF)
          f.msg_type = 8'($urandom_range(255, sb.highest_type + 1));
        else
          f.version = 8'd0;
      end
      BAD_ZERO_COUNT: begin
        f.frag_count = '0;
        f.frag_index = '0;
      end
      BAD_HUGE_COUNT: f.frag_count = 16'($urandom_range(65535, frt_pkg::FRAG_MAX + 1));
      BAD_INDEX:      f.frag_index = 16'($urandom_range(65535, f.frag_count));
      BAD_LENGTH:     f.payload_length = 16'($urandom_range(65535, frt_pkg::PAYLOAD_MAX + 1));
      BAD_RECEIVER:   f.receiver = sb.local_address ^ 8'($urandom_range(255, 1));
      default:        f = {$urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom)};
    endcase
    return f;
  endfunction

  // One message in shuffled order, with broken headers, duplicates and count
  // mismatches mixed in; nsend below cnt leaves the message unfinished.
  task automatic run_message(int cnt, int nsend);
    msg_id_t id;
    int      order[];
    int      j, tmp, roll, other_cnt;
    id = random_id();
    order = new[cnt];
    for (int i = 0; i < cnt; i++) order[i] = i;
    for (int i = cnt - 1; i > 0; i--) begin
      j = $urandom_range(i, 0);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    no_idle = ($urandom_range(6, 0) == 0);
    for (int i = 0; i < nsend; i++) begin
      roll = $urandom_range(99, 0);
      if (roll < 7) begin
        send_fragment(break_frag(make_frag(id, order[i], cnt)));
      end else if (roll < 11 && i > 0) begin
        send_fragment(make_frag(id, order[$urandom_range(i - 1, 0)], cnt));
      end else if (roll < 14) begin
        other_cnt = (cnt < frt_pkg::FRAG_MAX) ? cnt + 1 : cnt - 1;
        send_fragment(make_frag(id, 0, other_cnt));
      end
      send_fragment(make_frag(id, order[i], cnt));
    end
  endtask

  // Random messages until the phase has sent its share of words.
  task automatic run_phase(int quota);
    int target, cnt, nsend, roll;
    target = sent_total + quota;
    while (sent_total < target) begin
      roll = $urandom_range(99, 0);
      if (roll < 70) cnt = $urandom_range(8, 1);
      else if (roll < 94) cnt = $urandom_range(64, 9);
      else cnt = $urandom_range(frt_pkg::FRAG_MAX, 65);
      if (cnt > 64) nsend = $urandom_range(40, 8);
      else if (cnt > 1 && $urandom_range(9, 0) == 0) nsend = $urandom_range(cnt - 1, 1);
      else nsend = cnt;
      run_message(cnt, nsend);
    end
  endtask

  initial begin
    msg_id_t   id_a, id_b, id_c, id_zero;
    frag_hdr_t f;

    rst_n       <= 1'b0;
    in_tdata    <= '0;
    in_tvalid   <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed headers under the reset configuration: each malformed rule first.
    id_a = '{msg_type: 8'd1, sender: 8'd0, session: 64'h0123_4567_89AB_CDEF,
             sequence_req: 32'd0};
    f = make_frag(id_a, 0, 1); f.version = 8'd0;          send_fragment(f);
    f = make_frag(id_a, 0, 1); f.version = 8'hFF;         send_fragment(f);
    f = make_frag(id_a, 0, 1); f.msg_type = 8'd0;         send_fragment(f);
    f = make_frag(id_a, 0, 1); f.msg_type = 8'd5;         send_fragment(f);
    f = make_frag(id_a, 0, 1); f.msg_type = 8'hFF;        send_fragment(f);
    f = make_frag(id_a, 0, 0);                            send_fragment(f);
    f = make_frag(id_a, 0, frt_pkg::FRAG_MAX + 1);        send_fragment(f);
    f = make_frag(id_a, 0, 65535);                        send_fragment(f);
    f = make_frag(id_a, 3, 3);                            send_fragment(f);
    f = make_frag(id_a, 65535, frt_pkg::FRAG_MAX);        send_fragment(f);
    f = make_frag(id_a, 0, 1); f.payload_length = 16'd65; send_fragment(f);
    f = make_frag(id_a, 0, 1); f.payload_length = 16'hFFFF; send_fragment(f);
    f = make_frag(id_a, 0, 1); f.receiver = 8'hFF;        send_fragment(f);
    // Single-fragment message completes at once.
    f = make_frag(id_a, 0, 1); f.payload_length = 16'(frt_pkg::PAYLOAD_MAX); send_fragment(f);
    // Three fragments with a duplicate and a count mismatch in between.
    id_b = '{msg_type: 8'd4, sender: 8'hFF, session: '1, sequence_req: '1};
    f = make_frag(id_b, 2, 3); f.payload_length = 16'd0;  send_fragment(f);
    f = make_frag(id_b, 2, 3);                            send_fragment(f);
    f = make_frag(id_b, 0, 4);                            send_fragment(f);
    f = make_frag(id_b, 0, 3);                            send_fragment(f);
    f = make_frag(id_b, 1, 3);                            send_fragment(f);
    // Largest message: slot extremes, then abandoned for a new one that completes.
    id_c = '{msg_type: 8'd2, sender: 8'h5A, session: 64'hA5A5_0000_FFFF_1234,
             sequence_req: 32'h8000_0001};
    f = make_frag(id_c, frt_pkg::FRAG_MAX - 1, frt_pkg::FRAG_MAX); send_fragment(f);
    f = make_frag(id_c, 0, frt_pkg::FRAG_MAX);                     send_fragment(f);
    f = make_frag(id_c, frt_pkg::FRAG_MAX / 2, frt_pkg::FRAG_MAX); send_fragment(f);
    f = make_frag(id_b, 0, 1);                            send_fragment(f);

    // Type zero allowed: an all-zero identity continues the reset state and is rejected.
    set_config(8'h00, 8'h00, 8'h00);
    id_zero = '{msg_type: 8'd0, sender: 8'd0, session: '0, sequence_req: '0};
    f = make_frag(id_zero, 0, 1);                         send_fragment(f);
    f = make_frag(id_zero, 1, 2);                         send_fragment(f);
    run_phase(230);

    set_config(8'hFF, 8'h00, 8'hFF);
    run_phase(300);

    set_config(8'hFF, 8'hFF, 8'hFF);
    run_phase(200);

    set_config(8'($urandom_range(255, 0)), 8'($urandom_range(127, 0)),
               8'($urandom_range(255, 128)));
    run_phase(300);

    // Inverted type range: every header is malformed.
    set_config(8'($urandom_range(255, 0)), 8'd200, 8'd10);
    run_phase(100);

    set_config(8'($urandom_range(255, 0)), 8'd1, 8'd4);
    run_phase(280);

    // Drain the remaining verdict words.
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (8) @(posedge clk);
    if (sb.fails == 0) begin
      $display("PASS fragment_reassembly_tracker");
    end else begin
      $display("FAIL fragment_reassembly_tracker");
    end
    $finish;
  end

endmodule

// File: files.f
design/frt_pkg.sv
design/frt_cfg_regs.sv
design/frt_bitmap_mem.sv
design/frt_assembly.sv
design/fragment_reassembly_tracker.sv
design/frt_checker.sv
dv/tb_fragment_reassembly_tracker.sv
